// ===== hw/rtl/pcxc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcxc_pkg
// Shared types and constants for the chained XOR packet codec.
// ----------------------------------------------------------------------------
package pcxc_pkg;

    // Header layout
    localparam int HEADER_BYTES = 5;
    localparam int KEY_POS      = 3;
    localparam int CHECK_POS    = HEADER_BYTES - 1;
    localparam int POS_W        = $clog2(HEADER_BYTES + 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH  = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_KEY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_CODE = 1'b1;

    typedef enum logic [1:0] {
        MODE_ENCODE = 2'd0,
        MODE_DECODE = 2'd1,
        MODE_CHECK  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CODE = 2'd1,
        ST_BAD_SUM  = 2'd2,
        ST_SHORT    = 2'd3
    } t_status;

    // Byte class as seen by the front
    typedef enum logic [2:0] {
        K_FIRST,
        K_HEADER,
        K_KEY,
        K_CHECK,
        K_PAYLOAD
    } t_kind;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
        logic [1:0] status;
        logic [7:0] computed_sum;
    } t_out_item;

    // Classified item handed from front to back
    typedef struct packed {
        t_kind      kind;
        t_mode      mode;
        logic [7:0] data;
        logic       last;
    } t_cls;

    function automatic t_mode op_to_mode(input logic [1:0] op);
        t_mode m;
        case (op)
            2'd0:    m = MODE_ENCODE;
            2'd1:    m = MODE_DECODE;
            default: m = MODE_CHECK;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pcxc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcxc_front
// Tracks byte position and packet mode, and classifies each accepted item.
// ----------------------------------------------------------------------------
module pcxc_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire pcxc_pkg::t_in_item i_item,
    output pcxc_pkg::t_cls          o_cls
);
    import pcxc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    t_mode            r_mode, n_mode;
    t_kind            kind;

    always_comb begin
        if (r_pos == '0) begin
            kind = K_FIRST;
        end else if (r_pos < POS_W'(KEY_POS)) begin
            kind = K_HEADER;
        end else if (r_pos == POS_W'(KEY_POS)) begin
            kind = K_KEY;
        end else if (r_pos == POS_W'(CHECK_POS)) begin
            kind = K_CHECK;
        end else begin
            kind = K_PAYLOAD;
        end
    end

    // Mode is taken from the op field of byte 0 only
    assign n_mode = (r_pos == '0) ? op_to_mode(i_item.op) : r_mode;

    always_comb begin
        n_pos = r_pos;
        if (i_item.last_byte) begin
            n_pos = '0;
        end else if (r_pos < POS_W'(HEADER_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    assign o_cls = '{kind: kind, mode: n_mode, data: i_item.data_byte,
                     last: i_item.last_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_mode <= MODE_ENCODE;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_mode <= n_mode;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pcxc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcxc_queue
// Short register FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module pcxc_queue #(
    parameter int DEPTH = pcxc_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pcxc_pkg::t_cls i_item,
    output logic                o_ready,
    input  wire logic           i_pop,
    output logic                o_valid,
    output pcxc_pkg::t_cls      o_item
);
    import pcxc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pcxc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcxc_back
// Runs the XOR chains, checksum and status, and holds the result register.
// ----------------------------------------------------------------------------
module pcxc_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [7:0]          i_fixed_key,
    input  wire logic [7:0]          i_header_code,
    input  wire logic                i_q_valid,
    input  wire pcxc_pkg::t_cls      i_q_item,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output pcxc_pkg::t_out_item      o_item
);
    import pcxc_pkg::*;

    // Per-packet chain state, set up by the first byte of each packet
    logic [7:0] r_step, n_step;
    logic [7:0] r_prev_plain, n_prev_plain;
    logic [7:0] r_prev_cipher, n_prev_cipher;
    logic [7:0] r_rkey, n_rkey;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_rcheck, n_rcheck;
    logic       r_code_match, n_code_match;

    logic       r_valid;
    t_out_item  r_out, n_out;

    logic [7:0] key_a, key_b, inner, outer, plain, result;
    t_status    status;

    assign o_pop   = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_out;

    assign key_a = r_prev_plain + r_rkey + r_step;
    assign key_b = r_prev_cipher + i_fixed_key + r_step;

    always_comb begin
        inner = i_q_item.data;
        outer = i_q_item.data;
        plain = i_q_item.data;
        case (i_q_item.mode)
            MODE_ENCODE: begin
                inner = i_q_item.data ^ key_a;
                outer = inner ^ key_b;
            end
            MODE_DECODE: begin
                inner = i_q_item.data ^ key_b;
                outer = inner ^ key_a;
                plain = outer;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_step        = r_step;
        n_prev_plain  = r_prev_plain;
        n_prev_cipher = r_prev_cipher;
        n_rkey        = r_rkey;
        n_sum         = r_sum;
        n_rcheck      = r_rcheck;
        n_code_match  = r_code_match;
        result        = i_q_item.data;
        case (i_q_item.kind)
            K_FIRST: begin
                n_step        = 8'd1;
                n_prev_plain  = '0;
                n_prev_cipher = '0;
                n_rkey        = '0;
                n_sum         = '0;
                n_rcheck      = '0;
                n_code_match  = (i_q_item.mode == MODE_ENCODE) ||
                                (i_q_item.data == i_header_code);
            end
            K_KEY: begin
                n_rkey = i_q_item.data;
            end
            K_CHECK, K_PAYLOAD: begin
                n_step = r_step + 8'd1;
                if (i_q_item.mode == MODE_ENCODE) begin
                    n_prev_plain  = inner;
                    n_prev_cipher = outer;
                    result        = outer;
                end else if (i_q_item.mode == MODE_DECODE) begin
                    n_prev_plain  = inner;
                    n_prev_cipher = i_q_item.data;
                    result        = outer;
                end
                if (i_q_item.kind == K_PAYLOAD) begin
                    n_sum = r_sum + plain;
                end else begin
                    n_rcheck = plain;
                end
            end
            default: begin
            end
        endcase
    end

    // Short packet outranks bad code, bad code outranks bad checksum
    always_comb begin
        status = ST_OK;
        if (i_q_item.last) begin
            if (i_q_item.kind == K_FIRST || i_q_item.kind == K_HEADER ||
                i_q_item.kind == K_KEY) begin
                status = ST_SHORT;
            end else if (i_q_item.mode != MODE_ENCODE && !n_code_match) begin
                status = ST_BAD_CODE;
            end else if (i_q_item.mode != MODE_ENCODE && n_sum != n_rcheck) begin
                status = ST_BAD_SUM;
            end
        end
    end

    assign n_out = '{out_byte: result, last_out: i_q_item.last,
                     status: status, computed_sum: n_sum};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_step        <= n_step;
            r_prev_plain  <= n_prev_plain;
            r_prev_cipher <= n_prev_cipher;
            r_rkey        <= n_rkey;
            r_sum         <= n_sum;
            r_rcheck      <= n_rcheck;
            r_code_match  <= n_code_match;
            r_out         <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/packet_chained_xor_codec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted input item is written into the queue, then popped into the result register that drives the output.
// Throughput: one item per cycle, sustained, when the output side takes each result.
// The front feeds a queue of QUEUE_DEPTH items, so input ready drops only once that queue is full.
// Reset (synchronous, active low) empties queue and result register, clears both keys.
// The first item after reset is header byte 0 of a new packet.
// ----------------------------------------------------------------------------
// packet_chained_xor_codec
// Byte-serial packet encoder, decoder and checker with a two-stage chained XOR.
// ----------------------------------------------------------------------------
module packet_chained_xor_codec #(
    parameter int QUEUE_DEPTH = pcxc_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [pcxc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire pcxc_pkg::t_in_item             i_in_item,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output pcxc_pkg::t_out_item                 o_out_item
);
    import pcxc_pkg::*;

    logic [7:0] r_fixed_key;
    logic [7:0] r_header_code;

    logic       in_accept;
    t_cls       front_cls;
    logic       q_valid;
    t_cls       q_item;
    logic       q_pop;

    // Hold the keys; the user must write them only while the block is idle (the block itself does not enforce this)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_key   <= '0;
            r_header_code <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIXED_KEY:   r_fixed_key   <= i_cfg_data;
                CFG_HEADER_CODE: r_header_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_accept = i_in_valid && o_in_ready;

    // Front: track position and mode, tag each item with its class
    pcxc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_cls    (front_cls)
    );

    // Queue: decouple acceptance from result delivery
    pcxc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (front_cls),
        .o_ready (o_in_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back: advance the chains and present one result item per queued item
    pcxc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fixed_key   (r_fixed_key),
        .i_header_code (r_header_code),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_item        (o_out_item)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/pcxc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcxc_checker
// Port-level checks for the chained XOR packet codec.
// ----------------------------------------------------------------------------
module pcxc_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                o_in_ready,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_ready,
    input  wire pcxc_pkg::t_out_item o_out_item
);
    import pcxc_pkg::*;

    // Items accepted but not yet delivered
    logic [7:0] r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 8'(i_in_valid && o_in_ready)
                                   - 8'(o_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 8'd0)
        else $error("result item without an accepted input item");

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last_out |-> o_out_item.status == ST_OK)
        else $error("status set on a result that is not last");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

bind packet_chained_xor_codec pcxc_checker u_pcxc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire
